// ----- hw/rtl/rau_pkg.sv -----
// Shared types and codes for the rational arithmetic unit.
// Used by the front end, the operation core, the top level and the checker.
`default_nettype none

package rau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DEN  = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // Classification of one operation, produced by the front end.
    typedef struct packed {
        t_cmd    cmd;
        logic    a_neg;
        logic    b_neg;
        t_status status;
    } t_cls;

endpackage

`default_nettype wire

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: reduces each raw result by a binary GCD loop and a bit-serial divider.
// Invalid operands go straight to the result register, and a zero result skips the GCD loop and
// the divider. One operation is in the core at a time, so the GCD loop and the bit-serial
// divider set the throughput; a two-entry queue takes beats meanwhile. Synchronous active-low
// reset empties the queue and clears the result valid.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic [1:0]       o_status
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $bits(rau_pkg::t_cls);
    localparam int QW = CW + 4 * VW;

    // Front end outputs, packed together for the queue.
    rau_pkg::t_cls f_cls;
    logic [VW-1:0] f_am, f_ad, f_bm, f_bd;
    logic          f_push;

    // Queue outputs towards the core.
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    rau_pkg::t_cls c_cls;

    // The front end never waits on the core: it stalls only when the queue is full.
    rau_front #(
        .VALUE_WIDTH (VW)
    ) u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (i_cmd),
        .i_a_num (i_a_num),
        .i_a_den (i_a_den),
        .i_b_num (i_b_num),
        .i_b_den (i_b_den),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_cls   (f_cls),
        .o_a_mag (f_am),
        .o_a_den (f_ad),
        .o_b_mag (f_bm),
        .o_b_den (f_bd)
    );

    rau_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cls, f_am, f_ad, f_bm, f_bd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign c_cls = rau_pkg::t_cls'(q_data[QW-1 -: CW]);

    // The core forms the cross products, reduces the raw result by its GCD and
    // holds the finished beat in its own register until the sink takes it.
    rau_core #(
        .VALUE_WIDTH (VW)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_cls     (c_cls),
        .i_a_mag   (q_data[4*VW-1 -: VW]),
        .i_a_den   (q_data[3*VW-1 -: VW]),
        .i_b_mag   (q_data[2*VW-1 -: VW]),
        .i_b_den   (q_data[VW-1:0]),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_status  (o_status)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rau_front.sv -----
// Front end: takes input beats, splits operands into sign and magnitude
// and flags invalid operands. Depends on rau_pkg.
`default_nettype none

module rau_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_cmd,
    input  wire logic [31:0]            i_a_num,
    input  wire logic [31:0]            i_a_den,
    input  wire logic [31:0]            i_b_num,
    input  wire logic [31:0]            i_b_den,
    input  wire logic                   i_full,
    output logic                        o_push,
    output rau_pkg::t_cls               o_cls,
    output logic [VALUE_WIDTH-1:0]      o_a_mag,
    output logic [VALUE_WIDTH-1:0]      o_a_den,
    output logic [VALUE_WIDTH-1:0]      o_b_mag,
    output logic [VALUE_WIDTH-1:0]      o_b_den
);

    localparam int VW = VALUE_WIDTH;

    logic [VW-1:0] an, ad, bn, bd;

    always_comb begin
        an = i_a_num[VW-1:0];
        ad = i_a_den[VW-1:0];
        bn = i_b_num[VW-1:0];
        bd = i_b_den[VW-1:0];

        // Magnitudes fit VW unsigned bits, the most negative value included.
        o_a_mag = an[VW-1] ? (~an + VW'(1)) : an;
        o_a_den = ad[VW-1] ? (~ad + VW'(1)) : ad;
        o_b_mag = bn[VW-1] ? (~bn + VW'(1)) : bn;
        o_b_den = bd[VW-1] ? (~bd + VW'(1)) : bd;

        o_cls.cmd   = rau_pkg::t_cmd'(i_cmd);
        o_cls.a_neg = an[VW-1] ^ ad[VW-1];
        o_cls.b_neg = bn[VW-1] ^ bd[VW-1];
        if (ad == '0 || bd == '0) begin
            o_cls.status = rau_pkg::ST_ZERO_DEN;
        end else if (rau_pkg::t_cmd'(i_cmd) == rau_pkg::CMD_DIV && bn == '0) begin
            o_cls.status = rau_pkg::ST_DIV_ZERO;
        end else begin
            o_cls.status = rau_pkg::ST_OK;
        end

        o_stall = i_full;
        o_push  = i_valid && !i_full;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rau_queue.sv -----
// Two-entry queue between the front end and the operation core.
// Generic payload width; no package dependency.
`default_nettype none

module rau_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [WIDTH-1:0]       o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

// ----- hw/rtl/rau_core.sv -----
// Operation core: shared multiplier, binary GCD loop, paired restoring
// dividers and the result register. Depends on rau_pkg.
`default_nettype none

module rau_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    output logic                        o_q_pop,
    input  wire rau_pkg::t_cls          i_cls,
    input  wire logic [VALUE_WIDTH-1:0] i_a_mag,
    input  wire logic [VALUE_WIDTH-1:0] i_a_den,
    input  wire logic [VALUE_WIDTH-1:0] i_b_mag,
    input  wire logic [VALUE_WIDTH-1:0] i_b_den,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [31:0]                 o_res_num,
    output logic [30:0]                 o_res_den,
    output logic [1:0]                  o_status
);

    localparam int VW = VALUE_WIDTH;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int KW = $clog2(PW);
    localparam logic [PW-1:0] LIM = PW'(1) << (VW - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_GCD, S_DIV, S_CHK, S_OUT
    } t_state;

    t_state          r_state;
    rau_pkg::t_cls   r_cls;
    logic [VW-1:0]   r_am, r_ad, r_bm, r_bd;
    logic [1:0]      r_step;
    logic [PW-1:0]   r_t1, r_t2, r_den;
    logic            r_neg;
    logic [PW-1:0]   r_x, r_y;
    logic [KW-1:0]   r_k;
    logic [KW-1:0]   r_cnt;
    logic [PW-1:0]   r_qm, r_qd, r_rm, r_rd;
    logic            r_valid;
    logic [31:0]     r_num;
    logic [30:0]     r_den_o;
    logic [1:0]      r_status;

    logic [VW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   prod;
    logic            s1, s2;
    logic [PW-1:0]   sum_mag;
    logic            sum_neg;
    logic [PW:0]     rm_sh, rd_sh, dvs;
    logic            ge_m, ge_d;
    logic [PW-1:0]   n_rm, n_rd;
    logic [VW-1:0]   num_v;
    logic            ovf;

    always_comb begin
        // Shared multiplier: one product a cycle over three steps.
        case (r_step)
            2'd0: begin
                mul_a = r_am;
                mul_b = (r_cls.cmd == rau_pkg::CMD_MUL) ? r_bm : r_bd;
            end
            2'd1: begin
                mul_a = r_bm;
                mul_b = r_ad;
            end
            default: begin
                mul_a = r_ad;
                mul_b = (r_cls.cmd == rau_pkg::CMD_DIV) ? r_bm : r_bd;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);

        // Signed combination of the cross products.
        s1 = r_cls.a_neg;
        s2 = (r_cls.cmd == rau_pkg::CMD_SUB) ? !r_cls.b_neg : r_cls.b_neg;
        if (r_cls.cmd == rau_pkg::CMD_MUL || r_cls.cmd == rau_pkg::CMD_DIV) begin
            sum_mag = r_t1;
            sum_neg = r_cls.a_neg ^ r_cls.b_neg;
        end else if (s1 == s2) begin
            sum_mag = r_t1 + r_t2;
            sum_neg = s1;
        end else if (r_t1 >= r_t2) begin
            sum_mag = r_t1 - r_t2;
            sum_neg = s1;
        end else begin
            sum_mag = r_t2 - r_t1;
            sum_neg = s2;
        end

        // One restoring step for numerator and denominator together.
        dvs   = {1'b0, r_x};
        rm_sh = {r_rm, r_qm[PW-1]};
        rd_sh = {r_rd, r_qd[PW-1]};
        ge_m  = (rm_sh >= dvs);
        ge_d  = (rd_sh >= dvs);
        n_rm  = ge_m ? PW'(rm_sh - dvs) : rm_sh[PW-1:0];
        n_rd  = ge_d ? PW'(rd_sh - dvs) : rd_sh[PW-1:0];

        ovf   = (r_qd > LIM - PW'(1)) ||
                (r_neg ? (r_qm > LIM) : (r_qm > LIM - PW'(1)));
        num_v = r_neg ? (~r_qm[VW-1:0] + VW'(1)) : r_qm[VW-1:0];
    end

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid   = r_valid;
    assign o_res_num = r_num;
    assign o_res_den = r_den_o;
    assign o_status  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cls  <= i_cls;
                        r_am   <= i_a_mag;
                        r_ad   <= i_a_den;
                        r_bm   <= i_b_mag;
                        r_bd   <= i_b_den;
                        r_step <= 2'd0;
                        if (i_cls.status != rau_pkg::ST_OK) begin
                            r_num    <= '0;
                            r_den_o  <= '0;
                            r_status <= i_cls.status;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 2'd1;
                    case (r_step)
                        2'd0:    r_t1 <= prod;
                        2'd1:    r_t2 <= prod;
                        default: begin
                            r_den   <= prod;
                            r_state <= S_SUM;
                        end
                    endcase
                end
                S_SUM: begin
                    if (sum_mag == '0) begin
                        r_num    <= '0;
                        r_den_o  <= 31'd1;
                        r_status <= rau_pkg::ST_OK;
                        r_valid  <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_t1    <= sum_mag;
                        r_neg   <= sum_neg;
                        r_x     <= sum_mag;
                        r_y     <= r_den;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_x == r_y) begin
                        // Divide out the power of two counted in r_k now; r_x is the remaining factor of the GCD.
                        r_qm    <= r_t1 >> r_k;
                        r_qd    <= r_den >> r_k;
                        r_rm    <= '0;
                        r_rd    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x > r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
                S_DIV: begin
                    r_rm  <= n_rm;
                    r_rd  <= n_rd;
                    r_qm  <= {r_qm[PW-2:0], ge_m};
                    r_qd  <= {r_qd[PW-2:0], ge_d};
                    r_cnt <= r_cnt + KW'(1);
                    if (r_cnt == KW'(PW - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (ovf) begin
                        r_num    <= '0;
                        r_den_o  <= '0;
                        r_status <= rau_pkg::ST_OVERFLOW;
                    end else begin
                        r_num    <= 32'(signed'(num_v));
                        r_den_o  <= 31'(r_qd[VW-2:0]);
                        r_status <= rau_pkg::ST_OK;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rau_checker.sv -----
// Port-level checker for the rational arithmetic unit, with its bind.
// Depends on rau_pkg and the top level's ports.
`default_nettype none

module rau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_res_num,
    input wire logic [30:0] o_res_den,
    input wire logic [1:0]  o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_num) && $stable(o_res_den)
            && $stable(o_status))
        else $error("result beat changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rau_pkg::ST_OK |-> o_res_num == '0 && o_res_den == '0)
        else $error("failed result carries a value");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rau_pkg::ST_OK |-> o_res_den != '0)
        else $error("good result has zero denominator");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rau_pkg::ST_OK && o_res_num == '0 |-> o_res_den == 31'd1)
        else $error("zero result not normalised to 0/1");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_res_num (o_res_num),
    .o_res_den (o_res_den),
    .o_status  (o_status)
);

`default_nettype wire

// ----- dv/tb_rational_arithmetic_unit.sv -----
// Self-checking testbench for the rational arithmetic unit: directed and random beats,
// with each result checked by a hand-set answer or a behavioural model. Depends on rau_pkg.
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;

    localparam int VW = 32;

    typedef struct packed {
        logic [31:0]      num;
        logic [30:0]      den;
        rau_pkg::t_status status;
    } t_answer;

    // One directed beat. Where has_answer is set, the answer is written out by hand.
    typedef struct {
        rau_pkg::t_cmd    cmd;
        logic [31:0]      an, ad, bn, bd;
        bit               has_answer;
        logic [31:0]      num;
        logic [30:0]      den;
        rau_pkg::t_status status;
    } t_row;

    localparam logic [31:0] MIN = 32'h8000_0000;
    localparam logic [31:0] MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] M1  = 32'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = 2'd0;
    logic [31:0] i_a_num = '0, i_a_den = 32'd1, i_b_num = '0, i_b_den = 32'd1;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_res_num;
    logic [30:0] o_res_den;
    logic [1:0]  o_status;

    t_answer pending_answers[$];
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      sender_idle_pct = 0;
    int      stall_pct = 0;
    bit      stimulus_done = 1'b0;
    bit      hold_out = 1'b0;

    always #2 i_clk = ~i_clk;

    rational_arithmetic_unit #(.VALUE_WIDTH(VW)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_cmd    (i_cmd),
        .i_a_num  (i_a_num),
        .i_a_den  (i_a_den),
        .i_b_num  (i_b_num),
        .i_b_den  (i_b_den),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res_num(o_res_num),
        .o_res_den(o_res_den),
        .o_status (o_status)
    );

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Works out the reduced fraction that one operation yields, with its status.
    function automatic t_answer rational_result(rau_pkg::t_cmd cmd, logic [31:0] an_w,
                                                logic [31:0] ad_w, logic [31:0] bn_w,
                                                logic [31:0] bd_w);
        longint an, ad, bn, bd;
        longint unsigned am, adn, bm, bdn, g, t1, t2, mag, den;
        longint unsigned lim;
        bit      a_neg, b_neg, s2, neg;
        t_answer ans;
        an  = longint'(signed'(an_w));
        ad  = longint'(signed'(ad_w));
        bn  = longint'(signed'(bn_w));
        bd  = longint'(signed'(bd_w));
        ans = '{num: '0, den: '0, status: rau_pkg::ST_OK};
        lim = 64'd1 << (VW - 1);
        if (ad == 0 || bd == 0) begin
            ans.status = rau_pkg::ST_ZERO_DEN;
            return ans;
        end
        // Reduce each operand on magnitudes, sign carried separately.
        am  = (an < 0) ? -an : an;
        adn = (ad < 0) ? -ad : ad;
        bm  = (bn < 0) ? -bn : bn;
        bdn = (bd < 0) ? -bd : bd;
        a_neg = (an < 0) != (ad < 0);
        b_neg = (bn < 0) != (bd < 0);
        if (am == 0) begin
            a_neg = 1'b0; adn = 1;
        end else begin
            g = gcd64(am, adn); am = am / g; adn = adn / g;
        end
        if (bm == 0) begin
            b_neg = 1'b0; bdn = 1;
        end else begin
            g = gcd64(bm, bdn); bm = bm / g; bdn = bdn / g;
        end
        case (cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                t1 = am * bdn;
                t2 = bm * adn;
                s2 = (cmd == rau_pkg::CMD_SUB) ? !b_neg : b_neg;
                if (a_neg == s2) begin
                    mag = t1 + t2; neg = a_neg;
                end else if (t1 >= t2) begin
                    mag = t1 - t2; neg = a_neg;
                end else begin
                    mag = t2 - t1; neg = s2;
                end
                den = adn * bdn;
            end
            rau_pkg::CMD_MUL: begin
                mag = am * bm; den = adn * bdn; neg = a_neg != b_neg;
            end
            default: begin
                if (bm == 0) begin
                    ans.status = rau_pkg::ST_DIV_ZERO;
                    return ans;
                end
                mag = am * bdn; den = adn * bm; neg = a_neg != b_neg;
            end
        endcase
        if (mag == 0) begin
            neg = 1'b0; den = 1;
        end else begin
            g = gcd64(mag, den); mag = mag / g; den = den / g;
        end
        if (den > lim - 1 || (neg ? mag > lim : mag > lim - 1)) begin
            ans.status = rau_pkg::ST_OVERFLOW;
            return ans;
        end
        ans.num = neg ? 32'(-mag) : 32'(mag);
        ans.den = 31'(den);
        return ans;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %0t ns, result %0d: %s got %0h, want %0h",
                 $time, n_checked, field, got, want);
        n_errors++;
    endtask

    // Operand values: small numbers give plenty of common factors and zeros, extremes
    // hit the edges of the range, and full-width values exercise every bit.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($signed($urandom_range(24)) - 12);
            4: begin
                case ($urandom_range(5))
                    0: return MIN;
                    1: return MAX;
                    2: return M1;
                    3: return 32'd1;
                    4: return MIN + 32'd1;
                    default: return 32'd0;
                endcase
            end
            5: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // Offers one beat, holding it steady until the block takes it. The expected answer
    // is queued at the edge that accepts the beat.
    task automatic offer_beat(rau_pkg::t_cmd cmd, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd, t_answer ans);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_answers.push_back(ans);
        n_sent++;
    endtask

    // Stimulus: directed table first, then four random phases with different idling and stalling.
    initial begin
        t_row          rows[$];
        rau_pkg::t_cmd cmd;
        logic [31:0]   an, ad, bn, bd;
        t_answer       ans;
        int            pcts_s[4];
        int            pcts_r[4];

        rows = '{
            '{rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1, 32'd5, 31'd6, rau_pkg::ST_OK},
            '{rau_pkg::CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1, 32'd0, 31'd1, rau_pkg::ST_OK},
            '{rau_pkg::CMD_MUL, 32'd2, 32'd3, 32'd3, 32'd4, 1, 32'd1, 31'd2, rau_pkg::ST_OK},
            '{rau_pkg::CMD_DIV, 32'd1, 32'd2, 32'd1, 32'd4, 1, 32'd2, 31'd1, rau_pkg::ST_OK},
            '{rau_pkg::CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1, 32'd0, 31'd0,
              rau_pkg::ST_ZERO_DEN},
            // A zero denominator outranks the division by a zero fraction.
            '{rau_pkg::CMD_DIV, 32'd1, 32'd1, 32'd0, 32'd0, 1, 32'd0, 31'd0,
              rau_pkg::ST_ZERO_DEN},
            '{rau_pkg::CMD_DIV, 32'd5, 32'd7, 32'd0, 32'd3, 1, 32'd0, 31'd0,
              rau_pkg::ST_DIV_ZERO},
            '{rau_pkg::CMD_MUL, MIN, M1, 32'd1, 32'd1, 1, 32'd0, 31'd0, rau_pkg::ST_OVERFLOW},
            '{rau_pkg::CMD_MUL, MIN, 32'd1, 32'd1, 32'd1, 1, MIN, 31'd1, rau_pkg::ST_OK},
            '{rau_pkg::CMD_DIV, 32'd1, 32'd1, MIN, 32'd1, 1, 32'd0, 31'd0, rau_pkg::ST_OVERFLOW},
            '{rau_pkg::CMD_ADD, MAX, 32'd1, MAX, 32'd1, 1, 32'd0, 31'd0, rau_pkg::ST_OVERFLOW},
            '{rau_pkg::CMD_SUB, MIN, 32'd1, 32'd1, 32'd1, 1, 32'd0, 31'd0, rau_pkg::ST_OVERFLOW},
            '{rau_pkg::CMD_MUL, MAX, MAX, MIN, MIN, 1, 32'd1, 31'd1, rau_pkg::ST_OK},
            '{rau_pkg::CMD_ADD, 32'd0, -32'sd5, 32'd0, MIN, 1, 32'd0, 31'd1, rau_pkg::ST_OK},
            '{rau_pkg::CMD_DIV, -32'sd6, 32'd4, 32'd3, -32'sd2, 1, 32'd1, 31'd1, rau_pkg::ST_OK},
            '{rau_pkg::CMD_ADD, 32'd1, MAX, 32'd1, MAX - 32'd1, 0, '0, '0, rau_pkg::ST_OK},
            '{rau_pkg::CMD_SUB, 32'd3, MIN, -32'sd7, MAX, 0, '0, '0, rau_pkg::ST_OK},
            '{rau_pkg::CMD_MUL, M1, MIN, MIN, M1, 0, '0, '0, rau_pkg::ST_OK},
            '{rau_pkg::CMD_DIV, MAX, 32'd3, 32'd7, MIN, 0, '0, '0, rau_pkg::ST_OK},
            '{rau_pkg::CMD_SUB, MAX, M1, MIN, 32'd1, 0, '0, '0, rau_pkg::ST_OK},
            '{rau_pkg::CMD_DIV, M1, 32'h5555_5555, 32'hAAAA_AAAA, M1, 0, '0, '0, rau_pkg::ST_OK}
        };
        pcts_s = '{0, 63, 0, 11};
        pcts_r = '{0, 0, 63, 11};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].has_answer)
                ans = '{num: rows[k].num, den: rows[k].den, status: rows[k].status};
            else
                ans = rational_result(rows[k].cmd, rows[k].an, rows[k].ad,
                                      rows[k].bn, rows[k].bd);
            offer_beat(rows[k].cmd, rows[k].an, rows[k].ad, rows[k].bn, rows[k].bd, ans);
        end

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = pcts_s[p];
            stall_pct       = pcts_r[p];
            for (int k = 0; k < 500; k++) begin
                cmd = rau_pkg::t_cmd'($urandom_range(3));
                an  = pick_operand();
                ad  = pick_operand();
                bn  = pick_operand();
                bd  = pick_operand();
                offer_beat(cmd, an, ad, bn, bd, rational_result(cmd, an, ad, bn, bd));
            end
        end
        i_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Long output hold: once, early in the first random phase, the sink refuses results
    // so that the internal queue fills and the block has to stall its own input.
    initial begin
        int hold_left;
        wait (n_sent >= 40);
        @(negedge i_clk);
        hold_out  = 1'b1;
        hold_left = 3000;
        while (hold_left > 0) begin
            @(negedge i_clk);
            hold_left--;
        end
        hold_out = 1'b0;
    end

    // Result side: checks each accepted beat and decides the stall for the next edge.
    initial begin
        t_answer want;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall && i_rst_n) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected beat", 32'(o_status), 32'd0);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_res_num !== want.num)
                        report_mismatch("res_num", o_res_num, want.num);
                    if (o_res_den !== want.den)
                        report_mismatch("res_den", 32'(o_res_den), 32'(want.den));
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                n_checked++;
            end
            if (hold_out)
                i_stall <= 1'b1;
            else
                i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // End of run: drain, allow the block's latency to pass, then give the verdict.
    initial begin
        wait (stimulus_done);
        wait (pending_answers.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Covered %0d beats: directed edge cases, then four random phases", n_sent);
        $display("with and without idling and one long output hold; %0d results checked.",
                 n_checked);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d results outstanding.", pending_answers.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
